// ===== hw/rtl/bzsd_pkg.sv =====
package bzsd_pkg;

  // Default sizes
  localparam int unsigned MAX_ZONES_DEF     = 32;
  localparam int unsigned FRACTION_BITS_DEF = 16;

  // Field widths
  localparam int unsigned OWNER_W   = 16;
  localparam int unsigned POS_W     = 24;
  localparam int unsigned HALF_W    = 23;
  localparam int unsigned FEATHER_W = 16;

  // Distance arithmetic widths
  localparam int unsigned EXC_W  = POS_W;
  localparam int unsigned SQ_W   = 2 * EXC_W;
  localparam int unsigned SUM_W  = SQ_W + 1;
  localparam int unsigned ROOT_W = (SUM_W + 1) / 2;

  localparam logic [FEATHER_W-1:0] FEATHER_RESET = 16'd400;

  typedef enum logic [1:0] {
    OP_REG   = 2'd0,
    OP_UNREG = 2'd1,
    OP_QUERY = 2'd2
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_USCAN,
    ST_QSCAN,
    ST_QABS,
    ST_QEXC,
    ST_QSQR,
    ST_QSUM,
    ST_QROOT,
    ST_QDIV,
    ST_QT2,
    ST_QTERM,
    ST_QMIN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [OWNER_W-1:0]      owner;
    logic signed [POS_W-1:0] cx;
    logic signed [POS_W-1:0] cy;
    logic [HALF_W-1:0]       hx;
    logic [HALF_W-1:0]       hy;
  } zone_t;

  typedef struct packed {
    logic load;
    logic move;
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/bzsd_cell.sv =====
module bzsd_cell (
  input  logic                   clk_i,
  input  bzsd_pkg::cell_ctrl_t   ctrl_i,
  input  bzsd_pkg::zone_t        load_i,
  input  bzsd_pkg::zone_t        nb_i,
  output bzsd_pkg::zone_t        zone_o
);

  bzsd_pkg::zone_t zone_q;

  // Take a new zone, take the neighbor's zone, or hold
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      zone_q <= load_i;
    end else if (ctrl_i.move) begin
      zone_q <= nb_i;
    end
  end

  assign zone_o = zone_q;

endmodule

// ===== hw/rtl/bzsd_sqrt.sv =====
module bzsd_sqrt #(
  parameter int unsigned ROOT_W = bzsd_pkg::ROOT_W
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [2*ROOT_W-1:0]   radicand_i,
  output logic                  done_o,
  output logic [ROOT_W-1:0]     root_o
);

  localparam int unsigned RAD_W = 2 * ROOT_W;
  localparam int unsigned REM_W = ROOT_W + 2;
  localparam int unsigned CNT_W = $clog2(ROOT_W + 1);

  logic [RAD_W-1:0]  rad_q, rad_d;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [ROOT_W-1:0] root_q, root_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              done_q, done_d;

  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;

  // One root digit per cycle
  always_comb begin
    rem_sh = {rem_q[REM_W-3:0], rad_q[RAD_W-1:RAD_W-2]};
    trial  = {root_q, 2'b01};
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      rad_d  = radicand_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = CNT_W'(ROOT_W);
    end else if (cnt_q != '0) begin
      rad_d = {rad_q[RAD_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_d  = rem_sh - trial;
        root_d = {root_q[ROOT_W-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {root_q[ROOT_W-2:0], 1'b0};
      end
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// ===== hw/rtl/bzsd_div.sv =====
module bzsd_div #(
  parameter int unsigned QW = bzsd_pkg::FRACTION_BITS_DEF,
  parameter int unsigned DW = bzsd_pkg::FEATHER_W
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic          done_o,
  output logic [QW-1:0] quot_o
);

  localparam int unsigned CNT_W = $clog2(QW + 1);

  logic [DW-1:0]    rem_q, rem_d;
  logic [DW-1:0]    div_q, div_d;
  logic [QW-1:0]    quot_q, quot_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             done_q, done_d;

  logic [DW:0]      r2;
  logic [DW:0]      r2_sub;
  logic             ge;

  // One quotient bit per cycle, dividend below divisor
  always_comb begin
    r2     = {rem_q, 1'b0};
    r2_sub = r2 - {1'b0, div_q};
    ge     = (r2 >= {1'b0, div_q});
    rem_d  = rem_q;
    div_d  = div_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = dividend_i;
      div_d  = divisor_i;
      quot_d = '0;
      cnt_d  = CNT_W'(QW);
    end else if (cnt_q != '0) begin
      rem_d  = ge ? r2_sub[DW-1:0] : r2[DW-1:0];
      quot_d = {quot_q[QW-2:0], ge};
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    div_q  <= div_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ===== hw/rtl/box_zone_soft_distance_min_top.sv =====
// Register and unused ops: go to DONE, which registers the result once the output is free, then back to IDLE.
// Unregister: a scan of the stored zones, one chain step per zone looked at.
// Query: a scan of all MAX_ZONES slots; each stored zone goes through the distance steps and the root unit,
// and a zone inside the feather also goes through the divider and smoothstep.
// Reset (async, active low) empties the table, feather goes to 400; zone data is not cleared.
module box_zone_soft_distance_min_top #(
  parameter int unsigned MAX_ZONES     = bzsd_pkg::MAX_ZONES_DEF,
  parameter int unsigned FRACTION_BITS = bzsd_pkg::FRACTION_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [1:0]                            op_i,
  input  logic [bzsd_pkg::OWNER_W-1:0]          owner_id_i,
  input  logic signed [bzsd_pkg::POS_W-1:0]     pos_x_i,
  input  logic signed [bzsd_pkg::POS_W-1:0]     pos_y_i,
  input  logic [bzsd_pkg::HALF_W-1:0]           half_x_i,
  input  logic [bzsd_pkg::HALF_W-1:0]           half_y_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [FRACTION_BITS:0]                dustiness_o,
  output logic                                  status_o,
  output logic [$clog2(MAX_ZONES+1)-1:0]        removed_count_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [bzsd_pkg::FEATHER_W-1:0]        cfg_feather_distance_i
);

  localparam int unsigned FB     = FRACTION_BITS;
  localparam int unsigned CNT_W  = $clog2(MAX_ZONES + 1);
  localparam int unsigned IDX_W  = (MAX_ZONES > 1) ? $clog2(MAX_ZONES) : 1;
  localparam int unsigned FAC_W  = FB + 2;
  localparam int unsigned POS_W  = bzsd_pkg::POS_W;
  localparam int unsigned EXC_W  = bzsd_pkg::EXC_W;
  localparam int unsigned SQ_W   = bzsd_pkg::SQ_W;
  localparam int unsigned SUM_W  = bzsd_pkg::SUM_W;
  localparam int unsigned ROOT_W = bzsd_pkg::ROOT_W;
  localparam int unsigned FW     = bzsd_pkg::FEATHER_W;

  localparam logic [FB:0]      ONE_Q    = {1'b1, {FB{1'b0}}};
  localparam logic [FAC_W-1:0] THREE_Q  = FAC_W'(3) << FB;
  localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_ZONES);

  bzsd_pkg::state_e state_q, state_d;

  // Control registers
  logic [FW-1:0]    feather_q, feather_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;

  // Work registers
  logic [CNT_W-1:0]            k_q, k_d;
  logic [CNT_W-1:0]            removed_q, removed_d;
  logic                        status_q, status_d;
  logic [FB:0]                 dust_q, dust_d;
  logic [bzsd_pkg::OWNER_W-1:0] owner_q, owner_d;
  logic signed [POS_W-1:0]     px_q, px_d, py_q, py_d;
  logic [EXC_W-1:0]            ax_q, ax_d, ay_q, ay_d;
  logic [EXC_W-1:0]            ex_q, ex_d, ey_q, ey_d;
  logic [SQ_W-1:0]             sqx_q, sqx_d, sqy_q, sqy_d;
  logic [FB-1:0]               t2_q, t2_d;
  logic [FB:0]                 term_q, term_d;
  logic [FB:0]                 out_dust_q, out_dust_d;
  logic                        out_status_q, out_status_d;
  logic [CNT_W-1:0]            out_removed_q, out_removed_d;

  // Chain of zone cells
  bzsd_pkg::zone_t      zone_w [MAX_ZONES];
  bzsd_pkg::cell_ctrl_t ctrl_w [MAX_ZONES];
  bzsd_pkg::zone_t      load_zone;
  bzsd_pkg::zone_t      head;

  logic          acc_in;
  logic          out_free;
  logic          k_valid;
  logic          k_end;
  logic          match_k;
  logic          ld_en, rot_en, shl_en;
  logic [FW-1:0] f_eff;
  logic          root_ge;

  logic [POS_W:0]      dx, dy, dx_neg, dy_neg;
  logic [SUM_W-1:0]    sum;
  logic [2*FB-1:0]     tt;
  logic [FAC_W-1:0]    fac;
  logic [2*FB+1:0]     prod;

  // Iterative units
  logic              sqrt_start, sqrt_done;
  logic [ROOT_W-1:0] root;
  logic              div_start, div_done;
  logic [FB-1:0]     quot;

  assign acc_in     = in_valid_i & in_ready_o;
  assign in_ready_o = (state_q == bzsd_pkg::ST_IDLE);
  assign out_free   = !out_valid_q || out_ready_i;
  assign cfg_ready_o = 1'b1;

  assign k_valid = (k_q < cnt_q);
  assign k_end   = (k_q == MAX_CNT);
  assign head    = zone_w[0];
  assign match_k = (zone_w[k_q[IDX_W-1:0]].owner == owner_q);
  assign f_eff   = (feather_q == '0) ? FW'(1) : feather_q;
  assign root_ge = (root >= {{(ROOT_W-FW){1'b0}}, f_eff});

  assign ld_en  = acc_in && (op_i == bzsd_pkg::OP_REG);
  assign rot_en = ((state_q == bzsd_pkg::ST_QSCAN) && !k_end && !k_valid) ||
                  (state_q == bzsd_pkg::ST_QMIN);
  assign shl_en = (state_q == bzsd_pkg::ST_USCAN) && k_valid && match_k;

  assign load_zone.owner = owner_id_i;
  assign load_zone.cx    = pos_x_i;
  assign load_zone.cy    = pos_y_i;
  assign load_zone.hx    = half_x_i;
  assign load_zone.hy    = half_y_i;

  // Build the cell row; rotation wraps the head back to the tail
  for (genvar i = 0; i < MAX_ZONES; i++) begin : g_cell
    bzsd_pkg::zone_t nb;
    if (i < MAX_ZONES - 1) begin : g_mid
      assign nb = zone_w[i+1];
      assign ctrl_w[i].move = rot_en || (shl_en && (CNT_W'(i) >= k_q));
    end else begin : g_last
      assign nb = zone_w[0];
      assign ctrl_w[i].move = rot_en;
    end
    assign ctrl_w[i].load = ld_en && (cnt_q == CNT_W'(i));

    bzsd_cell u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl_w[i]),
      .load_i (load_zone),
      .nb_i   (nb),
      .zone_o (zone_w[i])
    );
  end

  assign sqrt_start = (state_q == bzsd_pkg::ST_QSUM);
  assign div_start  = (state_q == bzsd_pkg::ST_QROOT) && sqrt_done && !root_ge;

  bzsd_sqrt #(
    .ROOT_W (ROOT_W)
  ) u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i ({{(2*ROOT_W-SUM_W){1'b0}}, sum}),
    .done_o     (sqrt_done),
    .root_o     (root)
  );

  bzsd_div #(
    .QW (FB),
    .DW (FW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (root[FW-1:0]),
    .divisor_i  (f_eff),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      bzsd_pkg::ST_IDLE: begin
        if (acc_in) begin
          case (op_i)
            bzsd_pkg::OP_UNREG: state_d = bzsd_pkg::ST_USCAN;
            bzsd_pkg::OP_QUERY: state_d = bzsd_pkg::ST_QSCAN;
            default:            state_d = bzsd_pkg::ST_DONE;
          endcase
        end
      end
      bzsd_pkg::ST_USCAN: begin
        if (!k_valid) state_d = bzsd_pkg::ST_DONE;
      end
      bzsd_pkg::ST_QSCAN: begin
        if (k_end) begin
          state_d = bzsd_pkg::ST_DONE;
        end else if (k_valid) begin
          state_d = bzsd_pkg::ST_QABS;
        end
      end
      bzsd_pkg::ST_QABS:  state_d = bzsd_pkg::ST_QEXC;
      bzsd_pkg::ST_QEXC:  state_d = bzsd_pkg::ST_QSQR;
      bzsd_pkg::ST_QSQR:  state_d = bzsd_pkg::ST_QSUM;
      bzsd_pkg::ST_QSUM:  state_d = bzsd_pkg::ST_QROOT;
      bzsd_pkg::ST_QROOT: begin
        if (sqrt_done) state_d = root_ge ? bzsd_pkg::ST_QMIN : bzsd_pkg::ST_QDIV;
      end
      bzsd_pkg::ST_QDIV: begin
        if (div_done) state_d = bzsd_pkg::ST_QT2;
      end
      bzsd_pkg::ST_QT2:   state_d = bzsd_pkg::ST_QTERM;
      bzsd_pkg::ST_QTERM: state_d = bzsd_pkg::ST_QMIN;
      bzsd_pkg::ST_QMIN:  state_d = bzsd_pkg::ST_QSCAN;
      bzsd_pkg::ST_DONE: begin
        if (out_free) state_d = bzsd_pkg::ST_IDLE;
      end
      default: state_d = bzsd_pkg::ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    dx     = {px_q[POS_W-1], px_q} - {head.cx[POS_W-1], head.cx};
    dy     = {py_q[POS_W-1], py_q} - {head.cy[POS_W-1], head.cy};
    dx_neg = -dx;
    dy_neg = -dy;
    sum    = {1'b0, sqx_q} + {1'b0, sqy_q};
    tt     = quot * quot;
    fac    = THREE_Q - {1'b0, quot, 1'b0};
    prod   = t2_q * fac;

    feather_d     = cfg_valid_i ? cfg_feather_distance_i : feather_q;
    cnt_d         = cnt_q;
    k_d           = k_q;
    removed_d     = removed_q;
    status_d      = status_q;
    dust_d        = dust_q;
    owner_d       = owner_q;
    px_d          = px_q;
    py_d          = py_q;
    ax_d          = ax_q;
    ay_d          = ay_q;
    ex_d          = ex_q;
    ey_d          = ey_q;
    sqx_d         = sqx_q;
    sqy_d         = sqy_q;
    t2_d          = t2_q;
    term_d        = term_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    out_dust_d    = out_dust_q;
    out_status_d  = out_status_q;
    out_removed_d = out_removed_q;

    case (state_q)
      // Latch the request; a register op lands in its cell now unless the table is full
      bzsd_pkg::ST_IDLE: begin
        if (acc_in) begin
          owner_d   = owner_id_i;
          px_d      = pos_x_i;
          py_d      = pos_y_i;
          k_d       = '0;
          removed_d = '0;
          status_d  = (op_i == bzsd_pkg::OP_REG) && (cnt_q == MAX_CNT);
          dust_d    = (op_i == bzsd_pkg::OP_QUERY) ? ONE_Q : '0;
          if (ld_en && (cnt_q != MAX_CNT)) cnt_d = cnt_q + 1'b1;
        end
      end
      // Drop a matching zone by closing the gap, else advance
      bzsd_pkg::ST_USCAN: begin
        if (k_valid) begin
          if (match_k) begin
            cnt_d     = cnt_q - 1'b1;
            removed_d = removed_q + 1'b1;
          end else begin
            k_d = k_q + 1'b1;
          end
        end
      end
      // Skip empty slots while rotating the row
      bzsd_pkg::ST_QSCAN: begin
        if (!k_end && !k_valid) k_d = k_q + 1'b1;
      end
      bzsd_pkg::ST_QABS: begin
        ax_d = dx[POS_W] ? dx_neg[EXC_W-1:0] : dx[EXC_W-1:0];
        ay_d = dy[POS_W] ? dy_neg[EXC_W-1:0] : dy[EXC_W-1:0];
      end
      bzsd_pkg::ST_QEXC: begin
        ex_d = (ax_q > {1'b0, head.hx}) ? ax_q - {1'b0, head.hx} : '0;
        ey_d = (ay_q > {1'b0, head.hy}) ? ay_q - {1'b0, head.hy} : '0;
      end
      bzsd_pkg::ST_QSQR: begin
        sqx_d = ex_q * ex_q;
        sqy_d = ey_q * ey_q;
      end
      bzsd_pkg::ST_QROOT: begin
        if (sqrt_done && root_ge) term_d = ONE_Q;
      end
      bzsd_pkg::ST_QT2: begin
        t2_d = tt[2*FB-1:FB];
      end
      bzsd_pkg::ST_QTERM: begin
        term_d = prod[2*FB:FB];
      end
      // Keep the minimum and hand the next zone to the head
      bzsd_pkg::ST_QMIN: begin
        if (term_q < dust_q) dust_d = term_q;
        k_d = k_q + 1'b1;
      end
      bzsd_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_d   = 1'b1;
          out_dust_d    = dust_q;
          out_status_d  = status_q;
          out_removed_d = removed_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bzsd_pkg::ST_IDLE;
      feather_q   <= bzsd_pkg::FEATHER_RESET;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      feather_q   <= feather_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q           <= k_d;
    removed_q     <= removed_d;
    status_q      <= status_d;
    dust_q        <= dust_d;
    owner_q       <= owner_d;
    px_q          <= px_d;
    py_q          <= py_d;
    ax_q          <= ax_d;
    ay_q          <= ay_d;
    ex_q          <= ex_d;
    ey_q          <= ey_d;
    sqx_q         <= sqx_d;
    sqy_q         <= sqy_d;
    t2_q          <= t2_d;
    term_q        <= term_d;
    out_dust_q    <= out_dust_d;
    out_status_q  <= out_status_d;
    out_removed_q <= out_removed_d;
  end

  assign out_valid_o     = out_valid_q;
  assign dustiness_o     = out_dust_q;
  assign status_o        = out_status_q;
  assign removed_count_o = out_removed_q;

endmodule
